// File: hw/rtl/tlcc_pkg.sv
// Shared types and constants of the transpose-list chunk cache directory.
package tlcc_pkg;

    localparam int DEFAULT_ENTRIES = 16;
    localparam int TAG_W           = 32;
    localparam int KIND_W          = 2;
    localparam int SLOT_IO_W       = 4;

    localparam logic [KIND_W-1:0] KIND_LOOKUP  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

    typedef struct packed {
        logic              load;
        logic              exec;
        logic [KIND_W-1:0] kind;
        logic              key_en;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/tlcc_cell.sv
// One list position of the directory: a slot number, its tag and a match flag.
module tlcc_cell #(
    parameter int ENTRIES = tlcc_pkg::DEFAULT_ENTRIES
) (
    input  logic                                                clk,
    input  logic                                                rst_n,
    input  tlcc_pkg::cell_ctrl_t                                ctrl,
    input  logic                                                front,
    input  logic [$clog2(ENTRIES)+2*tlcc_pkg::TAG_W-1:0]        key,
    input  logic                                                left_valid,
    input  logic [$clog2(ENTRIES)+2*tlcc_pkg::TAG_W-1:0]        left_data,
    input  logic                                                right_valid,
    input  logic [$clog2(ENTRIES)+2*tlcc_pkg::TAG_W-1:0]        right_data,
    input  logic                                                right_first,
    input  logic                                                seen_in,
    output logic                                                seen_out,
    output logic                                                first,
    output logic                                                valid,
    output logic [$clog2(ENTRIES)+2*tlcc_pkg::TAG_W-1:0]        data
);
    import tlcc_pkg::*;

    localparam int SW = $clog2(ENTRIES);
    localparam int DW = SW + 2 * TAG_W;

    logic          valid_reg;
    logic          match_reg;
    logic          match_next;
    logic [DW-1:0] data_reg;
    logic          take_left;
    logic          take_right;

    assign first    = match_reg & ~seen_in;
    assign seen_out = seen_in | match_reg;
    assign valid    = valid_reg;
    assign data     = data_reg;

    always_comb
    begin
        case (ctrl.kind)
            KIND_LOOKUP:
                match_next = valid_reg && (key[2*TAG_W-1:0] == data_reg[2*TAG_W-1:0]);
            KIND_RELEASE:
                match_next = valid_reg && ctrl.key_en
                             && (key[DW-1 -: SW] == data_reg[DW-1 -: SW]);
            default:
                match_next = 1'b0;
        endcase
    end

    always_comb
    begin
        take_left  = 1'b0;
        take_right = 1'b0;
        if (ctrl.exec)
        begin
            case (ctrl.kind)
                KIND_LOOKUP:
                begin
                    take_left  = first & ~front;
                    take_right = right_first;
                end
                KIND_ALLOC:
                    take_left = 1'b1;
                KIND_RELEASE:
                    take_right = seen_out;
                default:
                begin
                    take_left  = 1'b0;
                    take_right = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
                match_reg <= match_next;
            if (take_left)
                valid_reg <= left_valid;
            else if (take_right)
                valid_reg <= right_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_left)
            data_reg <= left_data;
        else if (take_right)
            data_reg <= right_data;
    end

endmodule

// File: hw/rtl/transpose_list_chunk_cache.sv
// Top level of the transpose-list chunk cache directory.
//
//   channel   direction  handshake            fields
//   request   in         start / busy         kind, res_id, chunk_id, slot_in
//   response  out        done (strobe)        hit, slot_out, evicted, op_error
//
// In a transaction, the cycle of acceptance loads the tag compare
// into every cell and reads the free stack, the next cycle moves the cells.
// busy is high while the cells move; done follows in the cycle after that.
// Reset empties every cell and fills the free stack at once, no sweep.
// The receiver cannot stall: done is a single-cycle strobe.
module transpose_list_chunk_cache #(
    parameter int ENTRIES = tlcc_pkg::DEFAULT_ENTRIES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [tlcc_pkg::KIND_W-1:0]    kind,
    input  logic [tlcc_pkg::TAG_W-1:0]     res_id,
    input  logic [tlcc_pkg::TAG_W-1:0]     chunk_id,
    input  logic [tlcc_pkg::SLOT_IO_W-1:0] slot_in,
    output logic                           done,
    output logic                           hit,
    output logic [tlcc_pkg::SLOT_IO_W-1:0] slot_out,
    output logic                           evicted,
    output logic                           op_error
);
    import tlcc_pkg::*;

    localparam int SW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int DW = SW + 2 * TAG_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                 state_reg;
    logic                 accept;
    logic [KIND_W-1:0]    kind_reg;
    logic [TAG_W-1:0]     res_reg;
    logic [TAG_W-1:0]     chunk_reg;
    logic [SW-1:0]        req_slot;
    logic                 req_ok;
    logic [SW-1:0]        req_slot_reg;

    logic [CW-1:0]        free_count_reg;
    logic [CW-1:0]        free_count_next;
    logic [CW-1:0]        low_water_reg;
    logic [CW-1:0]        low_water_next;
    logic [CW-1:0]        count_m1;
    logic [SW-1:0]        pop_idx;
    logic [SW-1:0]        stack_mem [ENTRIES];
    logic [SW-1:0]        rd_reg;
    logic                 init_reg;
    logic [SW-1:0]        pop_slot;
    logic                 push_en;

    cell_ctrl_t           ctrl;
    logic [DW-1:0]        key;
    logic [DW-1:0]        ins_data;
    logic [SW-1:0]        alloc_slot;
    logic [SW-1:0]        tail_slot;
    logic [SW-1:0]        hit_slot;
    logic                 found;

    logic                 valid_w [ENTRIES+1];
    logic [DW-1:0]        data_w  [ENTRIES+1];
    logic                 seen_w  [ENTRIES+1];
    logic                 first_w [ENTRIES+1];

    logic                 done_reg;
    logic                 hit_reg;
    logic                 hit_next;
    logic [SLOT_IO_W-1:0] slot_out_reg;
    logic [SLOT_IO_W-1:0] slot_out_next;
    logic                 evicted_reg;
    logic                 evicted_next;
    logic                 op_error_reg;
    logic                 op_error_next;

    assign busy     = (state_reg == ST_EXEC);
    assign accept   = start && !busy;
    assign done     = done_reg;
    assign hit      = hit_reg;
    assign slot_out = slot_out_reg;
    assign evicted  = evicted_reg;
    assign op_error = op_error_reg;

    assign req_ok   = 32'(slot_in) < ENTRIES;
    assign req_slot = SW'(32'(slot_in));
    assign key      = {req_slot, res_id, chunk_id};

    assign ctrl.load   = accept;
    assign ctrl.exec   = busy;
    assign ctrl.kind   = busy ? kind_reg : kind;
    assign ctrl.key_en = req_ok;

    // free stack: positions never written since reset read as their reset slot
    assign count_m1 = free_count_reg - CW'(1);
    assign pop_idx  = (free_count_reg == '0) ? '0 : count_m1[SW-1:0];
    assign pop_slot = init_reg ? SW'(CW'(ENTRIES) - free_count_reg) : rd_reg;

    assign tail_slot  = data_w[ENTRIES-1][DW-1 -: SW];
    assign alloc_slot = (free_count_reg != '0) ? pop_slot : tail_slot;
    assign ins_data   = {alloc_slot, res_reg, chunk_reg};
    assign found      = seen_w[ENTRIES];
    assign push_en    = busy && (kind_reg == KIND_RELEASE) && found;

    assign valid_w[ENTRIES] = 1'b0;
    assign data_w[ENTRIES]  = '0;
    assign first_w[ENTRIES] = 1'b0;
    assign seen_w[0]        = 1'b0;

    generate
        for (genvar p = 0; p < ENTRIES; p++)
        begin : g_cell
            logic          left_valid;
            logic [DW-1:0] left_data;

            if (p == 0)
            begin : g_front
                assign left_valid = 1'b1;
                assign left_data  = ins_data;
            end
            else
            begin : g_inner
                assign left_valid = valid_w[p-1];
                assign left_data  = data_w[p-1];
            end

            tlcc_cell #(
                .ENTRIES (ENTRIES)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .front       (p == 0),
                .key         (key),
                .left_valid  (left_valid),
                .left_data   (left_data),
                .right_valid (valid_w[p+1]),
                .right_data  (data_w[p+1]),
                .right_first (first_w[p+1]),
                .seen_in     (seen_w[p]),
                .seen_out    (seen_w[p+1]),
                .first       (first_w[p]),
                .valid       (valid_w[p]),
                .data        (data_w[p])
            );
        end
    endgenerate

    always_comb
    begin
        hit_slot = '0;
        for (int p = 0; p < ENTRIES; p++)
        begin
            if (first_w[p])
                hit_slot = hit_slot | data_w[p][DW-1 -: SW];
        end
    end

    always_comb
    begin
        hit_next        = 1'b0;
        slot_out_next   = '0;
        evicted_next    = 1'b0;
        op_error_next   = 1'b0;
        free_count_next = free_count_reg;
        low_water_next  = low_water_reg;
        case (kind_reg)
            KIND_LOOKUP:
            begin
                hit_next = found;
                if (found)
                    slot_out_next = SLOT_IO_W'(32'(hit_slot));
            end
            KIND_ALLOC:
            begin
                slot_out_next = SLOT_IO_W'(32'(alloc_slot));
                if (free_count_reg == '0)
                    evicted_next = 1'b1;
                else
                begin
                    free_count_next = count_m1;
                    if (init_reg)
                        low_water_next = count_m1;
                end
            end
            KIND_RELEASE:
            begin
                op_error_next = !found;
                if (found)
                    free_count_next = free_count_reg + CW'(1);
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_count_reg <= CW'(ENTRIES);
            low_water_reg  <= CW'(ENTRIES);
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            slot_out_reg   <= '0;
            evicted_reg    <= 1'b0;
            op_error_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= busy;
            if (accept)
                state_reg <= ST_EXEC;
            else if (busy)
                state_reg <= ST_IDLE;
            if (busy)
            begin
                free_count_reg <= free_count_next;
                low_water_reg  <= low_water_next;
                hit_reg        <= hit_next;
                slot_out_reg   <= slot_out_next;
                evicted_reg    <= evicted_next;
                op_error_reg   <= op_error_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg     <= kind;
            res_reg      <= res_id;
            chunk_reg    <= chunk_id;
            req_slot_reg <= req_slot;
            rd_reg       <= stack_mem[pop_idx];
            init_reg     <= (free_count_reg == low_water_reg);
        end
        if (push_en)
            stack_mem[free_count_reg[SW-1:0]] <= req_slot_reg;
    end

endmodule

// File: hw/rtl/tlcc_checker.sv
// Port-level checks of the transpose-list chunk cache directory and their binding.
module tlcc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic       done,
    input logic       hit,
    input logic [3:0] slot_out,
    input logic       evicted,
    input logic       op_error
);

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy && done)
        else $error("busy did not end with a result strobe");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(hit && evicted) && !(hit && op_error) && !(evicted && op_error))
        else $error("conflicting result flags");

    a_error_slot: assert property (@(posedge clk) disable iff (!rst_n)
        done && op_error |-> slot_out == 4'd0)
        else $error("failed release reported a slot");

endmodule

bind transpose_list_chunk_cache tlcc_checker u_tlcc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .done     (done),
    .hit      (hit),
    .slot_out (slot_out),
    .evicted  (evicted),
    .op_error (op_error)
);

// File: tb/tb_transpose_list_chunk_cache.sv
// Self-checking testbench for the transpose-list chunk cache directory.
module tb_transpose_list_chunk_cache;
    timeunit 1ns;
    timeprecision 1ps;

    import tlcc_pkg::*;

    localparam int                NUM_SLOTS   = DEFAULT_ENTRIES;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int                POOL_SIZE   = 32;
    localparam int                CYCLE_LIMIT = 400000;
    localparam int                PRINT_LIMIT = 40;

    typedef struct packed {
        logic                 hit;
        logic [SLOT_IO_W-1:0] slot;
        logic                 evicted;
        logic                 op_error;
    } dir_resp_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [KIND_W-1:0]    kind = '0;
    logic [TAG_W-1:0]     res_id = '0;
    logic [TAG_W-1:0]     chunk_id = '0;
    logic [SLOT_IO_W-1:0] slot_in = '0;
    logic                 done;
    logic                 hit;
    logic [SLOT_IO_W-1:0] slot_out;
    logic                 evicted;
    logic                 op_error;

    logic [TAG_W-1:0]     tag_res [NUM_SLOTS];
    logic [TAG_W-1:0]     tag_chk [NUM_SLOTS];
    logic [SLOT_IO_W-1:0] used_list [NUM_SLOTS];
    logic [SLOT_IO_W-1:0] free_stk [NUM_SLOTS];
    int                   used_n;
    int                   free_n;

    logic [TAG_W-1:0]     pool_res [POOL_SIZE];
    logic [TAG_W-1:0]     pool_chk [POOL_SIZE];

    dir_resp_t            pending_resps [$];
    int                   mismatch_cnt = 0;
    int                   cycle_cnt = 0;
    int                   sent_cnt = 0;
    int                   hit_cnt = 0;
    int                   miss_cnt = 0;
    int                   evict_cnt = 0;
    int                   reject_cnt = 0;
    int                   released_cnt = 0;
    bit                   sender_no_gaps = 1'b0;

    transpose_list_chunk_cache dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .kind     (kind),
        .res_id   (res_id),
        .chunk_id (chunk_id),
        .slot_in  (slot_in),
        .done     (done),
        .hit      (hit),
        .slot_out (slot_out),
        .evicted  (evicted),
        .op_error (op_error)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d transactions pending",
                     cycle_cnt, pending_resps.size());
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= PRINT_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function automatic void clear_directory();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tag_res[i]   = '0;
            tag_chk[i]   = '0;
            used_list[i] = '0;
            free_stk[i]  = SLOT_IO_W'(NUM_SLOTS - 1 - i);
        end
        used_n = 0;
        free_n = NUM_SLOTS;
    endfunction

    function automatic dir_resp_t apply_directory_op(input logic [KIND_W-1:0] op,
                                                     input logic [TAG_W-1:0] rid,
                                                     input logic [TAG_W-1:0] cid,
                                                     input logic [SLOT_IO_W-1:0] req);
        dir_resp_t            r;
        int                   pos;
        logic [SLOT_IO_W-1:0] s;
        r   = '0;
        pos = -1;
        s   = '0;
        case (op)
            KIND_LOOKUP:
            begin
                for (int p = 0; p < used_n; p++)
                    if (pos < 0 && tag_res[used_list[p]] == rid && tag_chk[used_list[p]] == cid)
                        pos = p;
                if (pos >= 0)
                begin
                    s = used_list[pos];
                    if (pos > 0)
                    begin
                        used_list[pos]     = used_list[pos - 1];
                        used_list[pos - 1] = s;
                    end
                    r.hit  = 1'b1;
                    r.slot = s;
                end
            end
            KIND_ALLOC:
            begin
                if (free_n > 0)
                begin
                    free_n--;
                    s = free_stk[free_n];
                end
                else
                begin
                    r.evicted = 1'b1;
                    if (used_n > 0)
                    begin
                        s = used_list[used_n - 1];
                        used_n--;
                    end
                end
                tag_res[s] = rid;
                tag_chk[s] = cid;
                if (used_n >= NUM_SLOTS)
                    used_n = NUM_SLOTS - 1;
                for (int p = used_n; p > 0; p--)
                    used_list[p] = used_list[p - 1];
                used_list[0] = s;
                used_n++;
                r.slot = s;
            end
            KIND_RELEASE:
            begin
                for (int p = 0; p < used_n; p++)
                    if (pos < 0 && used_list[p] == req)
                        pos = p;
                if (pos >= 0)
                begin
                    for (int p = pos; p + 1 < used_n; p++)
                        used_list[p] = used_list[p + 1];
                    used_n--;
                    tag_res[req] = '0;
                    tag_chk[req] = '0;
                    if (free_n < NUM_SLOTS)
                    begin
                        free_stk[free_n] = req;
                        free_n++;
                    end
                end
                else
                    r.op_error = 1'b1;
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic issue_request(input logic [KIND_W-1:0] op,
                                 input logic [TAG_W-1:0] rid,
                                 input logic [TAG_W-1:0] cid,
                                 input logic [SLOT_IO_W-1:0] req);
        int        gap;
        dir_resp_t r;
        gap = sender_no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        kind     <= op;
        res_id   <= rid;
        chunk_id <= cid;
        slot_in  <= req;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        r = apply_directory_op(op, rid, cid, req);
        pending_resps.push_back(r);
        sent_cnt++;
        if (op == KIND_LOOKUP)
        begin
            if (r.hit)
                hit_cnt++;
            else
                miss_cnt++;
        end
        if (r.evicted)
            evict_cnt++;
        if (r.op_error)
            reject_cnt++;
        else if (op == KIND_RELEASE)
            released_cnt++;
    endtask

    task automatic wait_for_responses();
        start <= 1'b0;
        while (pending_resps.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin : check_resp
        dir_resp_t e;
        if (rst_n && done === 1'b1)
        begin
            if (pending_resps.size() == 0)
                report_mismatch("result with no transaction pending");
            else
            begin
                e = pending_resps.pop_front();
                if (hit !== e.hit)
                    report_mismatch($sformatf("hit %b, expected %b", hit, e.hit));
                if (slot_out !== e.slot)
                    report_mismatch($sformatf("slot_out %0d, expected %0d", slot_out, e.slot));
                if (evicted !== e.evicted)
                    report_mismatch($sformatf("evicted %b, expected %b", evicted, e.evicted));
                if (op_error !== e.op_error)
                    report_mismatch($sformatf("op_error %b, expected %b", op_error, e.op_error));
            end
        end
    end

    task automatic pick_lookup_tag(output logic [TAG_W-1:0] rid, output logic [TAG_W-1:0] cid);
        int roll;
        int idx;
        roll = $urandom_range(0, 99);
        if (roll < 60 && used_n > 0)
        begin
            idx = used_list[$urandom_range(0, used_n - 1)];
            rid = tag_res[idx];
            cid = tag_chk[idx];
        end
        else if (roll < 80)
        begin
            idx = $urandom_range(0, POOL_SIZE - 1);
            rid = pool_res[idx];
            cid = pool_chk[idx];
        end
        else if (roll < 90)
        begin
            idx = $urandom_range(0, POOL_SIZE - 1);
            rid = pool_res[idx];
            cid = $urandom;
        end
        else
        begin
            rid = $urandom;
            cid = $urandom;
        end
    endtask

    task automatic pick_alloc_tag(output logic [TAG_W-1:0] rid, output logic [TAG_W-1:0] cid);
        int idx;
        idx = $urandom_range(0, POOL_SIZE - 1);
        if ($urandom_range(0, 99) >= 40)
        begin
            pool_res[idx] = $urandom;
            pool_chk[idx] = $urandom;
        end
        rid = pool_res[idx];
        cid = pool_chk[idx];
    endtask

    // weights in percent; whatever is left over goes to the unused kind
    task automatic run_traffic(input int n, input int pct_lookup, input int pct_alloc,
                               input int pct_release);
        int                   roll;
        logic [TAG_W-1:0]     rid;
        logic [TAG_W-1:0]     cid;
        logic [SLOT_IO_W-1:0] req;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
                sender_no_gaps = ($urandom_range(0, 3) == 0);
            if (i > 0 && i % 150 == 0)
                wait_for_responses();
            roll = $urandom_range(0, 99);
            rid  = $urandom;
            cid  = $urandom;
            req  = SLOT_IO_W'($urandom_range(0, NUM_SLOTS - 1));
            if (roll < pct_lookup)
            begin
                pick_lookup_tag(rid, cid);
                issue_request(KIND_LOOKUP, rid, cid, req);
            end
            else if (roll < pct_lookup + pct_alloc)
            begin
                pick_alloc_tag(rid, cid);
                issue_request(KIND_ALLOC, rid, cid, req);
            end
            else if (roll < pct_lookup + pct_alloc + pct_release)
            begin
                if (used_n > 0 && $urandom_range(0, 99) < 75)
                    req = used_list[$urandom_range(0, used_n - 1)];
                issue_request(KIND_RELEASE, rid, cid, req);
            end
            else
                issue_request(KIND_UNUSED, rid, cid, req);
        end
        sender_no_gaps = 1'b0;
    endtask

    task automatic test_directed();
        issue_request(KIND_LOOKUP, 32'h0, 32'h0, 4'd0);
        issue_request(KIND_RELEASE, 32'h0, 32'h0, 4'd15);
        issue_request(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        issue_request(KIND_ALLOC, 32'hFFFF_FFFF, 32'h0, 4'd0);
        issue_request(KIND_ALLOC, 32'h0, 32'hFFFF_FFFF, 4'd0);
        issue_request(KIND_ALLOC, 32'hFFFF_FFFF, 32'h0, 4'd0);
        issue_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'd0);
        issue_request(KIND_LOOKUP, 32'h0, 32'hFFFF_FFFF, 4'd0);
        issue_request(KIND_LOOKUP, 32'h0, 32'hFFFF_FFFF, 4'd0);
        issue_request(KIND_RELEASE, 32'h0, 32'h0, 4'd2);
        issue_request(KIND_RELEASE, 32'h0, 32'h0, 4'd2);
        issue_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'd0);
        issue_request(KIND_RELEASE, 32'h0, 32'h0, 4'd0);
        issue_request(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0, 4'd0);
        issue_request(KIND_ALLOC, 32'hAAAA_AAAA, 32'h5555_5555, 4'd0);
        issue_request(KIND_LOOKUP, 32'hAAAA_AAAA, 32'h5555_5555, 4'd0);
        wait_for_responses();
    endtask

    task automatic test_fill_and_evict();
        logic [TAG_W-1:0] rid;
        logic [TAG_W-1:0] cid;
        for (int i = 0; i < 2 * NUM_SLOTS; i++)
        begin
            pick_alloc_tag(rid, cid);
            issue_request(KIND_ALLOC, rid, cid, 4'd0);
        end
        run_traffic(250, 40, 50, 8);
        wait_for_responses();
    endtask

    task automatic test_mixed_traffic();
        run_traffic(600, 45, 30, 20);
        wait_for_responses();
    endtask

    task automatic test_release_churn();
        run_traffic(250, 25, 33, 40);
        wait_for_responses();
    endtask

    initial
    begin
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_res[i] = $urandom;
            pool_chk[i] = $urandom;
        end
        clear_directory();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_fill_and_evict();
        test_mixed_traffic();
        test_release_churn();

        if (pending_resps.size() != 0)
            report_mismatch($sformatf("%0d transactions never answered", pending_resps.size()));
        $display("Ran %0d transactions: %0d lookup hits, %0d misses, %0d evictions,",
                 sent_cnt, hit_cnt, miss_cnt, evict_cnt);
        $display("%0d slots released, %0d bad releases; %0d mismatches",
                 released_cnt, reject_cnt, mismatch_cnt);
        if (mismatch_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
